FILE: src/mwf_pkg.sv
// Shared types and constants of the median window filter.
package mwf_pkg;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 12;
    localparam int COORD_W   = 11;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] RESET_FRAME_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_FRAME_HEIGHT = DIM_W'(480);

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t             px;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             has_med;
        logic             has_bord;
    } mwf_meta_t;

    typedef struct packed {
        pix_t      med;
        mwf_meta_t meta;
    } mwf_entry_t;

endpackage

FILE: src/mwf_line_ram.sv
// Line store RAM: one write port and one registered read port.
module mwf_line_ram #(
    parameter int DEPTH = 2048,
    parameter int DW    = 16,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/mwf_sorter.sv
// Pipelined odd-even transposition sorter that yields the window median.
module mwf_sorter import mwf_pkg::*; #(
    parameter int N = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [N-1:0][PIX_W-1:0] in_win,
    input  mwf_meta_t             in_meta,
    output logic                  out_valid,
    output pix_t                  out_med,
    output mwf_meta_t             out_meta
);

    localparam int NSTG = (N + 1) / 2;

    logic [N-1:0][PIX_W-1:0] stg [0:NSTG];
    logic                    vld [0:NSTG];
    mwf_meta_t               mta [0:NSTG];

    assign stg[0] = in_win;
    assign vld[0] = in_valid;
    assign mta[0] = in_meta;

    for (genvar s = 0; s < NSTG; s++)
    begin : g_stage
        logic [N-1:0][PIX_W-1:0] ra;
        logic [N-1:0][PIX_W-1:0] rb;

        always_comb
        begin
            ra = stg[s];
            for (int k = 0; k + 1 < N; k += 2)
            begin
                if (stg[s][k] > stg[s][k+1])
                begin
                    ra[k]   = stg[s][k+1];
                    ra[k+1] = stg[s][k];
                end
            end
            rb = ra;
            for (int k = 1; k + 1 < N; k += 2)
            begin
                if (ra[k] > ra[k+1])
                begin
                    rb[k]   = ra[k+1];
                    rb[k+1] = ra[k];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld[s+1] <= 1'b0;
            end
            else
            begin
                vld[s+1] <= vld[s];
            end
        end

        always_ff @(posedge clk)
        begin
            stg[s+1] <= rb;
            mta[s+1] <= mta[s];
        end
    end

    assign out_valid = vld[NSTG];
    assign out_med   = stg[NSTG][N/2];
    assign out_meta  = mta[NSTG];

endmodule

FILE: src/mwf_out_queue.sv
// Result queue that splits each entry into its median word and border word.
module mwf_out_queue import mwf_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int HALF  = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mwf_entry_t         push_entry,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   pixel_out,
    output logic [COORD_W-1:0] out_row,
    output logic [COORD_W-1:0] out_col,
    output logic               is_filtered,
    output logic               last_of_run,
    output logic               freed
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [DIM_W-1:0] HALF_D = DIM_W'(HALF);

    mwf_entry_t      q_mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            med_sent_reg;
    mwf_entry_t      head;
    logic            send_med;
    logic            pop;
    logic [DIM_W-1:0] med_row;
    logic [DIM_W-1:0] med_col;

    assign head      = q_mem[rd_ptr_reg];
    assign out_valid = (cnt_reg != CW'(0));
    assign send_med  = head.meta.has_med && !med_sent_reg;
    assign med_row   = head.meta.row - HALF_D;
    assign med_col   = head.meta.col - HALF_D;

    assign pixel_out   = send_med ? head.med : head.meta.px;
    assign out_row     = send_med ? med_row[COORD_W-1:0] : head.meta.row[COORD_W-1:0];
    assign out_col     = send_med ? med_col[COORD_W-1:0] : head.meta.col[COORD_W-1:0];
    assign is_filtered = send_med;
    assign last_of_run = !send_med || !head.meta.has_bord;

    assign pop   = out_valid && out_ready;
    assign freed = pop && last_of_run;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
            med_sent_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (freed)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                med_sent_reg <= !last_of_run;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(freed);
        end
    end

endmodule

FILE: src/median_window_filter.sv
// Top level: a new pixel word is taken every cycle while the result queue has credit.
// Path: a taken pixel passes the input register, window register and sorter stages, with
// two transposition rounds per stage, into the result queue. Throughput: one pixel per cycle
// through the line store read and write ports while the queue has credit; a pixel with two
// results gives two output words, median first. Reset clears counters, window, pipeline
// valids, queue and credits and restores the frame size; the line store is not cleared.
module median_window_filter import mwf_pkg::*; #(
    parameter int WIN        = 3,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIX_W-1:0]     pixel_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     pixel_out,
    output logic [COORD_W-1:0]   out_row,
    output logic [COORD_W-1:0]   out_col,
    output logic                 is_filtered,
    output logic                 last_of_run,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int HALF   = WIN / 2;
    localparam int NWIN   = WIN * WIN;
    localparam int NLINES = WIN - 1;
    localparam int LW     = NLINES * PIX_W;
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int NSTG   = (NWIN + 1) / 2;
    localparam int QDEPTH = 1 << $clog2(NSTG + 6);
    localparam int CRW    = $clog2(QDEPTH + 1);

    localparam logic [DIM_W:0] HALF_X = (DIM_W + 1)'(HALF);
    localparam logic [DIM_W:0] WM1_X  = (DIM_W + 1)'(WIN - 1);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] row_reg;
    logic [DIM_W-1:0] col_reg;
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;

    logic             s1_valid_reg;
    pix_t             s1_px_reg;
    logic [DIM_W-1:0] s1_row_reg;
    logic [DIM_W-1:0] s1_col_reg;
    logic             fwd_reg;
    logic [LW-1:0]    fwd_data_reg;
    logic [LW-1:0]    ram_rd_data;
    logic [LW-1:0]    rd_line;
    logic [LW-1:0]    wdata;
    logic [WIN-1:0][PIX_W-1:0] column;

    logic [NWIN-1:0][PIX_W-1:0] win_reg;
    logic             s2_valid_reg;
    mwf_meta_t        s2_meta_reg;
    mwf_meta_t        s1_meta;

    logic             srt_valid;
    pix_t             srt_med;
    mwf_meta_t        srt_meta;
    mwf_entry_t       q_entry;
    logic             q_push;
    logic             discard;
    logic             q_freed;
    logic [CRW-1:0]   credit_reg;

    logic             in_acc;
    logic             cfg_acc;
    logic             cfg_hit;

    function automatic logic is_bord(input logic [DIM_W:0] r, input logic [DIM_W:0] c,
                                     input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        return (r < HALF_X) || (r + HALF_X >= {1'b0, h}) ||
               (c < HALF_X) || (c + HALF_X >= {1'b0, w});
    endfunction

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = DIM_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
        if (height_reg == '0)
        begin
            eff_h = DIM_W'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            eff_h = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign in_ready  = (credit_reg < CRW'(QDEPTH));
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign cfg_hit   = (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT);
    assign col_inc   = col_reg + 1'b1;
    assign row_inc   = row_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_FRAME_WIDTH;
            height_reg <= RESET_FRAME_HEIGHT;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (cfg_acc && cfg_hit)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_acc)
        begin
            if (col_inc >= eff_w)
            begin
                col_reg <= '0;
                row_reg <= (row_inc >= eff_h) ? '0 : row_inc;
            end
            else
            begin
                col_reg <= col_inc;
            end
        end
    end

    mwf_line_ram #(
        .DEPTH (MAX_WIDTH),
        .DW    (LW),
        .AW    (AW)
    ) u_line_ram (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (AW'(col_reg)),
        .rd_data (ram_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (AW'(s1_col_reg)),
        .wr_data (wdata)
    );

    assign rd_line = fwd_reg ? fwd_data_reg : ram_rd_data;

    always_comb
    begin
        column[0] = s1_px_reg;
        for (int k = 1; k < WIN; k++)
        begin
            column[k] = rd_line[(k-1)*PIX_W +: PIX_W];
        end
        for (int k = 0; k < NLINES; k++)
        begin
            wdata[k*PIX_W +: PIX_W] = column[k];
        end
    end

    always_comb
    begin
        s1_meta.px       = s1_px_reg;
        s1_meta.row      = s1_row_reg;
        s1_meta.col      = s1_col_reg;
        s1_meta.has_bord = is_bord({1'b0, s1_row_reg}, {1'b0, s1_col_reg}, eff_w, eff_h);
        s1_meta.has_med  = ({1'b0, s1_row_reg} >= WM1_X) && ({1'b0, s1_col_reg} >= WM1_X) &&
                           !is_bord({1'b0, s1_row_reg} - HALF_X, {1'b0, s1_col_reg} - HALF_X,
                                    eff_w, eff_h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
            if (in_acc)
            begin
                fwd_reg <= s1_valid_reg && (s1_col_reg == col_reg);
            end
            if (s1_valid_reg)
            begin
                for (int i = 0; i < WIN; i++)
                begin
                    for (int j = 0; j < WIN - 1; j++)
                    begin
                        win_reg[i*WIN + j] <= win_reg[i*WIN + j + 1];
                    end
                    win_reg[i*WIN + WIN - 1] <= column[WIN - 1 - i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_px_reg    <= pixel_in;
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            fwd_data_reg <= wdata;
        end
        s2_meta_reg <= s1_meta;
    end

    mwf_sorter #(
        .N (NWIN)
    ) u_sorter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_win    (win_reg),
        .in_meta   (s2_meta_reg),
        .out_valid (srt_valid),
        .out_med   (srt_med),
        .out_meta  (srt_meta)
    );

    assign q_push      = srt_valid && (srt_meta.has_med || srt_meta.has_bord);
    assign discard     = srt_valid && !(srt_meta.has_med || srt_meta.has_bord);
    assign q_entry.med = srt_med;
    assign q_entry.meta = srt_meta;

    mwf_out_queue #(
        .DEPTH (QDEPTH),
        .HALF  (HALF)
    ) u_out_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (q_push),
        .push_entry  (q_entry),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .is_filtered (is_filtered),
        .last_of_run (last_of_run),
        .freed       (q_freed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_reg + CRW'(in_acc) - CRW'(q_freed) - CRW'(discard);
        end
    end

endmodule
